// File: sv/qcpn_pkg.sv
// ----------------------------------------------------------------------------
// qcpn_pkg
// Shared types and constants for the plane quad corner pipeline.
// ----------------------------------------------------------------------------
package qcpn_pkg;

	localparam int CW     = 32;  // component width, Q16.16
	localparam int SQ_W   = 64;  // width of the sum of squares
	localparam int ROOT_W = 32;  // width of the integer root
	localparam int QT_W   = 17;  // quotient bits of one unit component
	localparam int NUM_W  = 49;  // dividend width
	localparam int RV_W   = 18;  // signed width of a unit component
	localparam int FRAC   = 16;

	// Centre point and normal travelling alongside the arithmetic.
	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic signed [CW-1:0] nz;
	} pn_t;

	// Side data through the square-root pipeline.
	typedef struct packed {
		pn_t            pn;
		logic [CW-1:0]  ma;
		logic [CW-1:0]  mb;
		logic           sa;
		logic           sb;
		logic           zero;
	} sq_side_t;

	// Side data through the divider pipeline.
	typedef struct packed {
		pn_t  pn;
		logic sa;
		logic sb;
		logic zero;
	} dv_side_t;

endpackage

// File: sv/quad_corners_from_point_normal_core.sv
// ----------------------------------------------------------------------------
// quad_corners_from_point_normal_core
// Four corners of a plane quad from a centre point and a normal, Q16.16.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Payload
//  command   start / busy     point_x/y/z, normal_x/y/z
//  result    done (strobe)    top_left_*, top_right_*, bottom_left_*, bottom_right_*
//
// Each command transaction yields exactly one result transaction, which
// passes the front end, the square-root pipeline (32 stages, one root bit
// each), the divider (17 stages, one quotient bit each), the cross-product
// multipliers and the corner adders.
// A new transaction is taken in every cycle; busy is always low.
// The receiver cannot stall, so the pipeline never stops. Reset clears the
// valid bits only; payload registers are not reset.
//
// The right vector is the normalised (nz, 0, -nx), or (ny, -nx, 0) when both
// nx and nz are zero; its middle component is therefore always zero. Up is the
// cross product of the normal with right, rounded half up to Q16.16, and every
// corner is summed at full width before saturation to the 32-bit range.
module quad_corners_from_point_normal_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [qcpn_pkg::CW-1:0]  point_x,
	input  logic signed [qcpn_pkg::CW-1:0]  point_y,
	input  logic signed [qcpn_pkg::CW-1:0]  point_z,
	input  logic signed [qcpn_pkg::CW-1:0]  normal_x,
	input  logic signed [qcpn_pkg::CW-1:0]  normal_y,
	input  logic signed [qcpn_pkg::CW-1:0]  normal_z,
	output logic                            done,
	output logic signed [qcpn_pkg::CW-1:0]  top_left_x,
	output logic signed [qcpn_pkg::CW-1:0]  top_left_y,
	output logic signed [qcpn_pkg::CW-1:0]  top_left_z,
	output logic signed [qcpn_pkg::CW-1:0]  top_right_x,
	output logic signed [qcpn_pkg::CW-1:0]  top_right_y,
	output logic signed [qcpn_pkg::CW-1:0]  top_right_z,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_left_x,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_left_y,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_left_z,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_right_x,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_right_y,
	output logic signed [qcpn_pkg::CW-1:0]  bottom_right_z
);
	import qcpn_pkg::*;

	localparam int PW = CW + RV_W;  // product width
	localparam int XW = PW + 1;     // width of a difference of products
	localparam int UW = XW + 1 - FRAC;
	localparam int SW = UW + 2;     // corner sum width

	// Saturate a wide corner sum to the 32-bit range.
	function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] hi, lo;
		hi = SW'($signed({1'b0, {(CW-1){1'b1}}}));
		lo = SW'($signed({1'b1, {(CW-1){1'b0}}}));
		if (x > hi) begin
			sat = hi[CW-1:0];
		end else if (x < lo) begin
			sat = lo[CW-1:0];
		end else begin
			sat = x[CW-1:0];
		end
	endfunction

	// Round a Q19.32 difference to Q20.16, half up.
	function automatic logic signed [UW-1:0] rnd(input logic signed [XW-1:0] x);
		logic signed [XW:0] t;
		t   = (XW+1)'(x) + (XW+1)'(32'sd32768);
		rnd = t[XW:FRAC];
	endfunction

	pn_t       in_pn;
	logic      fe_valid, sq_valid, dv_valid;
	logic [SQ_W-1:0]   fe_sum;
	sq_side_t  fe_side, sq_side;
	logic [ROOT_W-1:0] sq_root;
	logic signed [RV_W-1:0] dv_ra, dv_rb;
	dv_side_t  dv_side;

	logic [2:0] v_q;
	pn_t        pn_s1, pn_s2;
	logic signed [RV_W-1:0] ra_s1, rb_s1, ra_s2, rb_s2;
	logic signed [PW-1:0]   pu0_s1, p1a_s1, p1b_s1, pu2_s1;
	logic signed [UW-1:0]   u0_s2, u1_s2, u2_s2;
	logic signed [CW-1:0]   tl_x, tl_y, tl_z, tr_x, tr_y, tr_z;
	logic signed [CW-1:0]   bl_x, bl_y, bl_z, br_x, br_y, br_z;

	assign busy     = 1'b0;
	assign in_pn.px = point_x;
	assign in_pn.py = point_y;
	assign in_pn.pz = point_z;
	assign in_pn.nx = normal_x;
	assign in_pn.ny = normal_y;
	assign in_pn.nz = normal_z;

	qcpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_pn     (in_pn),
		.out_valid (fe_valid),
		.out_sum   (fe_sum),
		.out_side  (fe_side)
	);

	qcpn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_sum    (fe_sum),
		.in_side   (fe_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	qcpn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_len    (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_ra    (dv_ra),
		.out_rb    (dv_rb),
		.out_side  (dv_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[1:0], dv_valid};
		end
	end

	// With r = (ra, 0, rb): u = (ny*rb, nz*ra - nx*rb, -ny*ra).
	always_ff @(posedge clk) begin
		pn_s1  <= dv_side.pn;
		ra_s1  <= dv_ra;
		rb_s1  <= dv_rb;
		pu0_s1 <= PW'(dv_side.pn.ny) * PW'(dv_rb);
		p1a_s1 <= PW'(dv_side.pn.nz) * PW'(dv_ra);
		p1b_s1 <= PW'(dv_side.pn.nx) * PW'(dv_rb);
		pu2_s1 <= PW'(dv_side.pn.ny) * PW'(dv_ra);

		pn_s2 <= pn_s1;
		ra_s2 <= ra_s1;
		rb_s2 <= rb_s1;
		u0_s2 <= rnd(XW'(pu0_s1));
		u1_s2 <= rnd(XW'(p1a_s1) - XW'(p1b_s1));
		u2_s2 <= rnd(-XW'(pu2_s1));

		tl_x <= sat(SW'(pn_s2.px) - SW'(ra_s2) + SW'(u0_s2));
		tr_x <= sat(SW'(pn_s2.px) + SW'(ra_s2) + SW'(u0_s2));
		bl_x <= sat(SW'(pn_s2.px) - SW'(ra_s2) - SW'(u0_s2));
		br_x <= sat(SW'(pn_s2.px) + SW'(ra_s2) - SW'(u0_s2));
		tl_y <= sat(SW'(pn_s2.py) + SW'(u1_s2));
		tr_y <= sat(SW'(pn_s2.py) + SW'(u1_s2));
		bl_y <= sat(SW'(pn_s2.py) - SW'(u1_s2));
		br_y <= sat(SW'(pn_s2.py) - SW'(u1_s2));
		tl_z <= sat(SW'(pn_s2.pz) - SW'(rb_s2) + SW'(u2_s2));
		tr_z <= sat(SW'(pn_s2.pz) + SW'(rb_s2) + SW'(u2_s2));
		bl_z <= sat(SW'(pn_s2.pz) - SW'(rb_s2) - SW'(u2_s2));
		br_z <= sat(SW'(pn_s2.pz) + SW'(rb_s2) - SW'(u2_s2));
	end

	assign done           = v_q[2];
	assign top_left_x     = tl_x;
	assign top_left_y     = tl_y;
	assign top_left_z     = tl_z;
	assign top_right_x    = tr_x;
	assign top_right_y    = tr_y;
	assign top_right_z    = tr_z;
	assign bottom_left_x  = bl_x;
	assign bottom_left_y  = bl_y;
	assign bottom_left_z  = bl_z;
	assign bottom_right_x = br_x;
	assign bottom_right_y = br_y;
	assign bottom_right_z = br_z;

endmodule

// File: sv/qcpn_front.sv
// ----------------------------------------------------------------------------
// qcpn_front
// Picks the 2-vector to normalise, scales it up and forms its sum of squares.
// ----------------------------------------------------------------------------
module qcpn_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  qcpn_pkg::pn_t               in_pn,
	output logic                        out_valid,
	output logic [qcpn_pkg::SQ_W-1:0]   out_sum,
	output qcpn_pkg::sq_side_t          out_side
);
	import qcpn_pkg::*;

	logic          case_a;
	logic signed [CW-1:0] a_c;
	logic [CW-1:0] ma_c, mb_c, m_c;
	logic          sa_c, sb_c;
	logic [4:0]    sh_c;

	logic [4:0]    v_q;
	pn_t           pn_s1, pn_s2, pn_s3, pn_s4, pn_s5;
	logic [CW-1:0] ma_s1, mb_s1, ma_s2, mb_s2, ma_s3, mb_s3, ma_s4, mb_s4, ma_s5, mb_s5;
	logic          sa_s1, sb_s1, z_s1, sa_s2, sb_s2, z_s2, sa_s3, sb_s3, z_s3;
	logic          sa_s4, sb_s4, z_s4, sa_s5, sb_s5, z_s5;
	logic [4:0]    sh_s2;
	logic [SQ_W-1:0] sqa_s4, sqb_s4, sum_s5;

	// Stage 1 selection: the right vector comes from (nz, -nx) or (ny, -nx).
	always_comb begin
		case_a = (in_pn.nx != '0) || (in_pn.nz != '0);
		a_c    = case_a ? in_pn.nz : in_pn.ny;
		sa_c   = a_c[CW-1];
		ma_c   = sa_c ? (~a_c + 1'b1) : a_c;
		sb_c   = case_a && !in_pn.nx[CW-1] && (in_pn.nx != '0);
		mb_c   = case_a ? (in_pn.nx[CW-1] ? (~in_pn.nx + 1'b1) : in_pn.nx) : '0;
	end

	// Stage 2: shift count that brings the larger magnitude to at least 2^30.
	always_comb begin
		m_c  = (ma_s1 > mb_s1) ? ma_s1 : mb_s1;
		sh_c = '0;
		for (int i = 0; i < CW-1; i++) begin
			if (m_c[i]) begin
				sh_c = 5'(CW-2-i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		pn_s1 <= in_pn;
		ma_s1 <= ma_c;
		mb_s1 <= mb_c;
		sa_s1 <= sa_c;
		sb_s1 <= sb_c;
		z_s1  <= (ma_c == '0) && (mb_c == '0);

		pn_s2 <= pn_s1; ma_s2 <= ma_s1; mb_s2 <= mb_s1;
		sa_s2 <= sa_s1; sb_s2 <= sb_s1; z_s2 <= z_s1; sh_s2 <= sh_c;

		pn_s3 <= pn_s2; ma_s3 <= ma_s2 << sh_s2; mb_s3 <= mb_s2 << sh_s2;
		sa_s3 <= sa_s2; sb_s3 <= sb_s2; z_s3 <= z_s2;

		pn_s4  <= pn_s3; ma_s4 <= ma_s3; mb_s4 <= mb_s3;
		sa_s4  <= sa_s3; sb_s4 <= sb_s3; z_s4 <= z_s3;
		sqa_s4 <= SQ_W'(ma_s3) * SQ_W'(ma_s3);
		sqb_s4 <= SQ_W'(mb_s3) * SQ_W'(mb_s3);

		pn_s5  <= pn_s4; ma_s5 <= ma_s4; mb_s5 <= mb_s4;
		sa_s5  <= sa_s4; sb_s5 <= sb_s4; z_s5 <= z_s4;
		sum_s5 <= sqa_s4 + sqb_s4;
	end

	assign out_valid     = v_q[4];
	assign out_sum       = sum_s5;
	assign out_side.pn   = pn_s5;
	assign out_side.ma   = ma_s5;
	assign out_side.mb   = mb_s5;
	assign out_side.sa   = sa_s5;
	assign out_side.sb   = sb_s5;
	assign out_side.zero = z_s5;

endmodule

// File: sv/qcpn_isqrt.sv
// ----------------------------------------------------------------------------
// qcpn_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qcpn_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [qcpn_pkg::SQ_W-1:0]    in_sum,
	input  qcpn_pkg::sq_side_t           in_side,
	output logic                         out_valid,
	output logic [qcpn_pkg::ROOT_W-1:0]  out_root,
	output qcpn_pkg::sq_side_t           out_side
);
	import qcpn_pkg::*;

	logic [SQ_W-1:0]   rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	sq_side_t          side_s [0:ROOT_W];
	logic [ROOT_W:0]   v_s;

	assign rem_s[0]  = in_sum;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_W+1:0] trial;
		logic            take;

		// Trial value 2*root*2^B + 2^(2B) against the remaining radicand.
		always_comb begin
			trial = ((SQ_W+2)'(root_s[k]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
			take  = (SQ_W+2)'(rem_s[k]) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			if (take) begin
				rem_s[k+1]  <= rem_s[k] - trial[SQ_W-1:0];
				root_s[k+1] <= root_s[k] | (ROOT_W'(1) << B);
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

// File: sv/qcpn_div.sv
// ----------------------------------------------------------------------------
// qcpn_div
// Rounded division of both magnitudes by the length, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qcpn_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [qcpn_pkg::ROOT_W-1:0]        in_len,
	input  qcpn_pkg::sq_side_t                 in_side,
	output logic                               out_valid,
	output logic signed [qcpn_pkg::RV_W-1:0]   out_ra,
	output logic signed [qcpn_pkg::RV_W-1:0]   out_rb,
	output qcpn_pkg::dv_side_t                 out_side
);
	import qcpn_pkg::*;

	logic [NUM_W-1:0]  ra_s [0:QT_W];
	logic [NUM_W-1:0]  rb_s [0:QT_W];
	logic [QT_W-1:0]   qa_s [0:QT_W];
	logic [QT_W-1:0]   qb_s [0:QT_W];
	logic [ROOT_W-1:0] len_s [0:QT_W];
	dv_side_t          side_s [0:QT_W];
	logic [QT_W+1:0]   v_s;
	logic signed [RV_W-1:0] ra_q, rb_q;
	dv_side_t          side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	// Dividend: magnitude as Q32.16 plus half the length for rounding.
	always_ff @(posedge clk) begin
		ra_s[0]      <= (NUM_W'(in_side.ma) << FRAC) + NUM_W'(in_len >> 1);
		rb_s[0]      <= (NUM_W'(in_side.mb) << FRAC) + NUM_W'(in_len >> 1);
		qa_s[0]      <= '0;
		qb_s[0]      <= '0;
		len_s[0]     <= in_len;
		side_s[0].pn <= in_side.pn;
		side_s[0].sa <= in_side.sa;
		side_s[0].sb <= in_side.sb;
		side_s[0].zero <= in_side.zero;
	end

	for (genvar k = 0; k < QT_W; k++) begin : g_stage
		localparam int B = QT_W - 1 - k;
		logic [NUM_W-1:0] dsr;
		logic             ta, tb;

		always_comb begin
			dsr = NUM_W'(len_s[k]) << B;
			ta  = ra_s[k] >= dsr;
			tb  = rb_s[k] >= dsr;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			len_s[k+1]  <= len_s[k];
			side_s[k+1] <= side_s[k];
			ra_s[k+1]   <= ta ? (ra_s[k] - dsr) : ra_s[k];
			rb_s[k+1]   <= tb ? (rb_s[k] - dsr) : rb_s[k];
			qa_s[k+1]   <= qa_s[k] | (QT_W'(ta) << B);
			qb_s[k+1]   <= qb_s[k] | (QT_W'(tb) << B);
		end
	end

	// Signs back on; a zero vector gives a zero right vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[QT_W+1] <= 1'b0;
		end else begin
			v_s[QT_W+1] <= v_s[QT_W];
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_s[QT_W];
		if (side_s[QT_W].zero) begin
			ra_q <= '0;
			rb_q <= '0;
		end else begin
			ra_q <= side_s[QT_W].sa ? -$signed(RV_W'(qa_s[QT_W])) : $signed(RV_W'(qa_s[QT_W]));
			rb_q <= side_s[QT_W].sb ? -$signed(RV_W'(qb_s[QT_W])) : $signed(RV_W'(qb_s[QT_W]));
		end
	end

	assign out_valid = v_s[QT_W+1];
	assign out_ra    = ra_q;
	assign out_rb    = rb_q;
	assign out_side  = side_q;

endmodule
